// File: src/edcc_pkg.sv
// shared types, constants and calendar helpers for the epoch day calendar converter
package edcc_pkg;

  // field widths
  localparam int unsigned DaysW  = 16;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned AccW   = 18;
  localparam int unsigned YdW    = 9;

  // default epoch year
  localparam int unsigned EpochYearDefault = 1958;

  // request selector codes
  localparam logic ReqToDate = 1'b0;
  localparam logic ReqToDays = 1'b1;

  // result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEarly = 2'd1;
  localparam logic [1:0] StMonth = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  // month lengths, february filled in by leap flag
  localparam logic [DayW-1:0] MonthLen [16] = '{
    5'd0, 5'd31, 5'd0, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };
  localparam logic [MonthW-1:0] FebMonth  = 4'd2;
  localparam logic [MonthW-1:0] LastMonth = 4'd12;

  typedef struct packed {
    logic              req_type;
    logic [DaysW-1:0]  day_count;
    logic [YearW-1:0]  year_in;
    logic [MonthW-1:0] month_in;
    logic [DayW-1:0]   day_in;
  } in_item_t;

  typedef struct packed {
    logic [DaysW-1:0]  days_out;
    logic [YearW-1:0]  year_out;
    logic [MonthW-1:0] month_out;
    logic [DayW-1:0]   day_out;
    logic [1:0]        status;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StYears,
    StMonths,
    StFinish
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step_year;
    logic step_month;
    logic write_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic year_more;
    logic month_more;
  } dp_stat_t;

  // length of month m, leap selects february
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    len = MonthLen[m];
    if (m == FebMonth) begin
      len = 5'd28 + {4'd0, leap};
    end
    return len;
  endfunction

endpackage

// File: src/edcc_ctrl.sv
// controller state machine for the epoch day calendar converter
module edcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output edcc_pkg::dp_cmd_t  cmd_o,
  input  edcc_pkg::dp_stat_t stat_i
);
  import edcc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output slot is free when empty or being taken now
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StYears;
      end
      StYears: begin
        if (!stat_i.year_more) state_d = StMonths;
      end
      StMonths: begin
        if (!stat_i.month_more) state_d = StFinish;
      end
      StFinish: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StYears:  cmd_o.step_year  = stat_i.year_more;
      StMonths: cmd_o.step_month = stat_i.month_more;
      StFinish: cmd_o.write_out  = out_free;
      default: ;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.write_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/edcc_dpath.sv
// datapath for the epoch day calendar converter: year and month stepping
module edcc_dpath #(
  parameter int unsigned EPOCH_YEAR = edcc_pkg::EpochYearDefault
) (
  input  logic                clk_i,
  input  edcc_pkg::in_item_t  in_data_i,
  input  edcc_pkg::dp_cmd_t   cmd_i,
  output edcc_pkg::dp_stat_t  stat_o,
  output edcc_pkg::out_item_t out_data_o
);
  import edcc_pkg::*;

  localparam logic [YearW-1:0] EpochY   = YearW'(EPOCH_YEAR);
  localparam logic [1:0]       EpochM4  = 2'(EPOCH_YEAR % 4);
  localparam logic [6:0]       EpochM100 = 7'(EPOCH_YEAR % 100);
  localparam logic [8:0]       EpochM400 = 9'(EPOCH_YEAR % 400);
  localparam logic [AccW-1:0]  CapCount = AccW'(65536);

  logic              mode_q;
  logic [1:0]        err_q;
  logic [YearW-1:0]  yin_q;
  logic [MonthW-1:0] min_q;
  logic [DayW-1:0]   din_q;
  logic [YearW-1:0]  y_q;
  logic [MonthW-1:0] m_q;
  logic [AccW-1:0]   acc_q;
  logic [1:0]        m4_q;
  logic [6:0]        m100_q;
  logic [8:0]        m400_q;
  out_item_t         res_q;

  logic              leap;
  logic [YdW-1:0]    ydays;
  logic [DayW-1:0]   mdays;
  logic [1:0]        err_new;
  logic [AccW:0]     sum;
  out_item_t         res_new;

  // leap year from running residues of the current year
  assign leap  = (m400_q == 9'd0) || ((m100_q != 7'd0) && (m4_q == 2'd0));
  assign ydays = 9'd365 + {8'd0, leap};
  assign mdays = month_days(m_q, leap);

  // loop conditions
  always_comb begin
    if (mode_q == ReqToDate) begin
      stat_o.year_more  = acc_q > AccW'(ydays);
      stat_o.month_more = (m_q < LastMonth) && (acc_q > AccW'(mdays));
    end else begin
      stat_o.year_more  = (err_q == StOk) && (y_q < yin_q) && (acc_q <= CapCount);
      stat_o.month_more = (err_q == StOk) && (m_q < min_q);
    end
  end

  // request check for date to count
  always_comb begin
    err_new = StOk;
    if (in_data_i.req_type == ReqToDays) begin
      if (in_data_i.year_in < EpochY) begin
        err_new = StEarly;
      end else if ((in_data_i.month_in < 4'd1) || (in_data_i.month_in > LastMonth)) begin
        err_new = StMonth;
      end
    end
  end

  // result assembly
  always_comb begin
    res_new = '0;
    sum     = acc_q + (AccW+1)'(din_q);
    if (mode_q == ReqToDate) begin
      res_new.year_out  = y_q;
      res_new.month_out = m_q;
      res_new.day_out   = acc_q[DayW-1:0];
      res_new.status    = StOk;
    end else if (err_q != StOk) begin
      res_new.status = err_q;
    end else if (sum == '0) begin
      res_new.status = StRange;
    end else if (sum > (AccW+1)'(65536)) begin
      res_new.status   = StRange;
      res_new.days_out = '1;
    end else begin
      res_new.days_out = DaysW'(sum - (AccW+1)'(1));
      res_new.status   = StOk;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_data_i.req_type;
      err_q  <= err_new;
      yin_q  <= in_data_i.year_in;
      min_q  <= in_data_i.month_in;
      din_q  <= in_data_i.day_in;
      y_q    <= EpochY;
      m_q    <= 4'd1;
      m4_q   <= EpochM4;
      m100_q <= EpochM100;
      m400_q <= EpochM400;
      if (in_data_i.req_type == ReqToDate) begin
        acc_q <= AccW'(in_data_i.day_count) + AccW'(1);
      end else begin
        acc_q <= '0;
      end
    end else if (cmd_i.step_year) begin
      if (mode_q == ReqToDate) acc_q <= acc_q - AccW'(ydays);
      else                     acc_q <= acc_q + AccW'(ydays);
      y_q    <= y_q + YearW'(1);
      m4_q   <= m4_q + 2'd1;
      m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
      m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
    end else if (cmd_i.step_month) begin
      if (mode_q == ReqToDate) acc_q <= acc_q - AccW'(mdays);
      else                     acc_q <= acc_q + AccW'(mdays);
      m_q <= m_q + MonthW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_out) res_q <= res_new;
  end

  assign out_data_o = res_q;

endmodule

// File: src/epoch_day_calendar_converter.sv
// top level of the epoch day calendar converter
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------
//   input   | in        | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//   output  | out       | out_valid_o/out_stall_i | out_data_o (out_item_t)
//
// one transaction at a time: Y whole years are stepped from the epoch (stopped
// once the count passes 16 bits) and M whole months are stepped, one per cycle
// through a single accumulator; the result is then written, and the next input
// is taken in the cycle after the result is written.
// reset clears the controller and the result valid flag, nothing else.
// a stalled result holds in the output register; input is taken again once
// the result is loaded there.
module epoch_day_calendar_converter #(
  parameter int unsigned EPOCH_YEAR = edcc_pkg::EpochYearDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  edcc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output edcc_pkg::out_item_t out_data_o
);
  import edcc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  edcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // year and month stepping datapath
  edcc_dpath #(
    .EPOCH_YEAR (EPOCH_YEAR)
  ) u_dpath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
